// ----- rtl/core/bfm_pkg.sv -----
// Shared types and constants for the Bloom filter block.
// No dependencies; bfm_hash and the top level use it by scoped names.
package bfm_pkg;

    localparam logic [1:0] FN_QUERY = 2'd0;
    localparam logic [1:0] FN_ADD   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    localparam logic [1:0] CFG_HASH_COUNT     = 2'd0;
    localparam logic [1:0] CFG_BIT_COUNT      = 2'd1;
    localparam logic [1:0] CFG_LAYER_CAPACITY = 2'd2;

    localparam int CFG_DATA_W = 17;

    localparam logic [31:0] SEED_ONE = 32'h9747b28c;
    localparam logic [31:0] SEED_TWO = 32'h5bd1e995;
    localparam logic [31:0] C_ONE    = 32'hcc9e2d51;
    localparam logic [31:0] C_TWO    = 32'h1b873593;
    localparam logic [31:0] C_MIX    = 32'he6546b64;
    localparam logic [31:0] C_FIN1   = 32'h85ebca6b;
    localparam logic [31:0] C_FIN2   = 32'hc2b2ae35;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        last_word;
    } t_req;

    typedef struct packed {
        logic        maybe_present;
        logic        is_full;
        logic [15:0] element_total;
    } t_rsp;

    typedef struct packed {
        logic done;
        logic last;
    } t_hash_evt;

endpackage

// ----- rtl/core/bfm_stream_if.sv -----
// Valid/ready channel carrying one payload of a chosen type.
// Uses no package; the payload type is given at instantiation.
interface bfm_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/bfm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bfm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/core/bfm_hash.sv -----
// Two MurmurHash3-32 lanes that share the key scramble, plus finalization.
// Depends on bfm_pkg.
module bfm_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_word,
    input  logic [2:0]           i_nbytes,
    input  logic                 i_last,
    output bfm_pkg::t_hash_evt   o_evt,
    output logic [31:0]          o_h1,
    output logic [31:0]          o_h2
);
    typedef enum logic [2:0] {
        H_IDLE, H_K1, H_K2, H_MIX, H_F1, H_F2, H_F3
    } t_hstate;

    t_hstate     r_state;
    logic [31:0] r_k, r_h1, r_h2, r_f1, r_f2;
    logic [15:0] r_len;
    logic        r_mix, r_body, r_last;
    logic [2:0]  nb;
    logic [31:0] masked, m1, m2, f1, f2, g1, g2;

    function automatic logic [31:0] mix_body(input logic [31:0] h, input logic [31:0] s);
        logic [31:0] x;
        x = h ^ s;
        x = {x[18:0], x[31:19]};
        return (x << 2) + x + bfm_pkg::C_MIX;
    endfunction

    always_comb begin
        nb = (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
        case (nb)
            3'd1:    masked = {24'd0, i_word[7:0]};
            3'd2:    masked = {16'd0, i_word[15:0]};
            3'd3:    masked = {8'd0, i_word[23:0]};
            default: masked = i_word;
        endcase
        m1 = r_body ? mix_body(r_h1, r_k) : (r_h1 ^ r_k);
        m2 = r_body ? mix_body(r_h2, r_k) : (r_h2 ^ r_k);
        f1 = r_h1 ^ {16'd0, r_len};
        f2 = r_h2 ^ {16'd0, r_len};
        f1 = f1 ^ (f1 >> 16);
        f2 = f2 ^ (f2 >> 16);
        g1 = r_f1 ^ (r_f1 >> 13);
        g2 = r_f2 ^ (r_f2 >> 13);
    end

    assign o_h1 = r_f1;
    assign o_h2 = r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_h1    <= bfm_pkg::SEED_ONE;
            r_h2    <= bfm_pkg::SEED_TWO;
            r_len   <= 16'd0;
            o_evt   <= '0;
        end else begin
            o_evt <= '0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_k     <= masked;
                        r_len   <= r_len + 16'(nb);
                        r_mix   <= (nb != 3'd0);
                        r_body  <= (nb == 3'd4);
                        r_last  <= i_last;
                        r_state <= H_K1;
                    end
                end
                H_K1: begin
                    r_k     <= r_k * bfm_pkg::C_ONE;
                    r_state <= H_K2;
                end
                H_K2: begin
                    r_k     <= {r_k[16:0], r_k[31:17]} * bfm_pkg::C_TWO;
                    r_state <= H_MIX;
                end
                H_MIX: begin
                    if (r_mix) begin
                        r_h1 <= m1;
                        r_h2 <= m2;
                    end
                    if (r_last) begin
                        r_state <= H_F1;
                    end else begin
                        o_evt   <= '{done: 1'b1, last: 1'b0};
                        r_state <= H_IDLE;
                    end
                end
                H_F1: begin
                    r_f1    <= f1 * bfm_pkg::C_FIN1;
                    r_f2    <= f2 * bfm_pkg::C_FIN1;
                    r_state <= H_F2;
                end
                H_F2: begin
                    r_f1    <= g1 * bfm_pkg::C_FIN2;
                    r_f2    <= g2 * bfm_pkg::C_FIN2;
                    r_state <= H_F3;
                end
                H_F3: begin
                    r_f1    <= r_f1 ^ (r_f1 >> 16);
                    r_f2    <= r_f2 ^ (r_f2 >> 16);
                    r_h1    <= bfm_pkg::SEED_ONE;
                    r_h2    <= bfm_pkg::SEED_TWO;
                    r_len   <= 16'd0;
                    o_evt   <= '{done: 1'b1, last: 1'b1};
                    r_state <= H_IDLE;
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/bfm_mod.sv -----
// Bit-serial restoring remainder of a 32-bit value by the filter size.
// No dependencies.
module bfm_mod #(
    parameter int CW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [CW-1:0] o_rem
);
    logic          r_busy;
    logic [4:0]    r_cnt;
    logic [31:0]   r_dvd;
    logic [CW-1:0] r_rem;
    logic [CW:0]   trial;

    assign trial = {r_rem, r_dvd[31]};
    assign o_rem = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[30:0], 1'b0};
                if (trial >= {1'b0, i_divisor}) begin
                    r_rem <= CW'(trial - {1'b0, i_divisor});
                end else begin
                    r_rem <= trial[CW-1:0];
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/core/bloom_filter_murmur3.sv -----
// Top level of the Bloom filter: request control, probe sequencing, bit store.
// Depends on bfm_pkg, bfm_stream_if, bfm_ram, bfm_hash and bfm_mod.
//
//  Channel   Dir  Payload         Handshake
//  i_req     in   bfm_pkg::t_req  valid/ready
//  o_rsp     out  bfm_pkg::t_rsp  valid/ready
//  i_cfg_*   in   index, data     write enable only
//
// A key word passes through the key scramble and mix; a last word adds finalization and
// then, per probe, a remainder from the one-bit-per-cycle remainder unit.
// Reset and the clear request sweep the bit store one bit per cycle; requests are
// held off meanwhile. A stalled response waits in its register and blocks only the
// next response.
module bloom_filter_murmur3 #(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_PROBES      = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bfm_stream_if.sink                     i_req,
    bfm_stream_if.source                   o_rsp,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [bfm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_FILTER_BITS);
    localparam int CW = $clog2(MAX_FILTER_BITS + 1);
    localparam int PW = $clog2(MAX_PROBES + 1);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_HASH, S_DIV, S_MEM, S_CHK, S_DONE, S_OUT
    } t_state;

    t_state             r_state;
    logic [4:0]         r_hash_count;
    logic [16:0]        r_bit_count;
    logic [15:0]        r_capacity;
    logic [15:0]        r_count;
    logic [1:0]         r_func;
    logic               r_present;
    logic [31:0]        r_x, r_step;
    logic [PW-1:0]      r_i;
    logic [AW-1:0]      r_addr;
    logic               r_we;
    logic               r_wdata;
    logic               r_ovalid;
    bfm_pkg::t_rsp      r_rsp;

    logic               rdata;
    bfm_pkg::t_hash_evt hevt;
    logic [31:0]        h1, h2;
    logic               div_start, div_done;
    logic [CW-1:0]      rem;
    logic [CW-1:0]      modulus;
    logic [PW-1:0]      probes;
    logic [5:0]         hc_ext;
    logic [24:0]        bc_ext;
    logic               req_fire;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        hc_ext = {1'b0, r_hash_count};
        if (hc_ext == 6'd0) begin
            probes = PW'(1);
        end else if (hc_ext > 6'(MAX_PROBES)) begin
            probes = PW'(MAX_PROBES);
        end else begin
            probes = PW'(hc_ext);
        end
        bc_ext = 25'(r_bit_count);
        if (bc_ext < 25'd64) begin
            modulus = CW'(64);
        end else if (bc_ext > 25'(MAX_FILTER_BITS)) begin
            modulus = CW'(MAX_FILTER_BITS);
        end else begin
            modulus = CW'(bc_ext);
        end
    end

    bfm_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (req_fire),
        .i_word   (i_req.payload.key_word),
        .i_nbytes (i_req.payload.word_bytes),
        .i_last   (i_req.payload.last_word),
        .o_evt    (hevt),
        .o_h1     (h1),
        .o_h2     (h2)
    );

    bfm_mod #(.CW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_x),
        .i_divisor  (modulus),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    bfm_ram #(.WIDTH(1), .DEPTH(MAX_FILTER_BITS)) u_bits (
        .i_clk   (i_clk),
        .i_addr  (r_addr),
        .i_we    (r_we),
        .i_wdata (r_wdata),
        .o_rdata (rdata)
    );

    // The remainder unit is kicked off on entry to S_DIV from a registered flag.
    logic r_div_go;
    assign div_start = r_div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_hash_count <= 5'd9;
            r_bit_count  <= 17'd65536;
            r_capacity   <= 16'd8192;
            r_count      <= 16'd0;
            r_func       <= bfm_pkg::FN_QUERY;
            r_present    <= 1'b0;
            r_addr       <= '0;
            r_we         <= 1'b1;
            r_wdata      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_div_go     <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bfm_pkg::CFG_HASH_COUNT:     r_hash_count <= i_cfg_data[4:0];
                    bfm_pkg::CFG_BIT_COUNT:      r_bit_count  <= i_cfg_data[16:0];
                    bfm_pkg::CFG_LAYER_CAPACITY: r_capacity   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // S_OUT owns the valid flag in its own cycles.
            if (r_ovalid && o_rsp.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (r_addr == AW'(MAX_FILTER_BITS - 1)) begin
                        r_we    <= 1'b0;
                        r_addr  <= '0;
                        r_state <= (r_func == bfm_pkg::FN_CLEAR && r_present) ? S_OUT
                                                                              : S_IDLE;
                        r_present <= 1'b0;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    r_present <= 1'b0;
                    if (req_fire) begin
                        r_func  <= i_req.payload.func;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hevt.done) begin
                        if (!hevt.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_x    <= h1;
                            r_step <= h2;
                            r_i    <= '0;
                            case (r_func)
                                bfm_pkg::FN_QUERY, bfm_pkg::FN_ADD: begin
                                    r_present <= 1'b1;
                                    r_div_go  <= 1'b1;
                                    r_state   <= S_DIV;
                                end
                                bfm_pkg::FN_CLEAR: begin
                                    // r_present marks a sweep that must answer.
                                    r_present <= 1'b1;
                                    r_count   <= 16'd0;
                                    r_addr    <= '0;
                                    r_we      <= 1'b1;
                                    r_wdata   <= 1'b0;
                                    r_state   <= S_SWEEP;
                                end
                                default: begin
                                    r_present <= 1'b0;
                                    r_state   <= S_OUT;
                                end
                            endcase
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_addr  <= rem[AW-1:0];
                        r_we    <= (r_func == bfm_pkg::FN_ADD);
                        r_wdata <= 1'b1;
                        r_state <= S_MEM;
                    end
                end
                S_MEM: begin
                    // Write completes or read data arrives next cycle.
                    r_we    <= 1'b0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_func == bfm_pkg::FN_QUERY && !rdata) begin
                        r_present <= 1'b0;
                        r_state   <= S_DONE;
                    end else if (r_i + PW'(1) == probes) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i      <= r_i + PW'(1);
                        r_x      <= r_x + r_step;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DONE: begin
                    if (r_func == bfm_pkg::FN_ADD && r_count != 16'hFFFF) begin
                        r_count <= r_count + 16'd1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_rsp    <= '{maybe_present: (r_func == bfm_pkg::FN_CLEAR) ? 1'b0
                                                                            : r_present,
                                      is_full:       (r_count >= r_capacity),
                                      element_total: r_count};
                        r_present <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
